[rtl/tdpt_pkg.sv]
// Shared types and codes for the trial division prime test.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package tdpt_pkg;

   localparam logic [1:0] DIV_THREE = 2'd0;
   localparam logic [1:0] DIV_D     = 2'd1;
   localparam logic [1:0] DIV_D2    = 2'd2;

   typedef struct packed {
      logic       load;
      logic       start_mod;
      logic [1:0] div_sel;
      logic       step;
      logic       set_result;
      logic       result_value;
      logic       push;
   } cmd_type;

   typedef struct packed {
      logic below_two;
      logic below_four;
      logic even;
      logic square_above;
      logic mod_idle;
      logic rem_zero;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

[rtl/tdpt_datapath.sv]
// Datapath of the prime test: magnitude, candidate divisor and its square,
// a bit-serial restoring remainder unit and the result register. Uses tdpt_pkg.
`default_nettype none

module tdpt_datapath
   import tdpt_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [VALUE_WIDTH-1:0] value,
   input  wire cmd_type                cmd,
   output      status_type             status,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic                   is_prime
);

   localparam int SW = VALUE_WIDTH + 4;
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] n_ff, n_in;
   logic [VALUE_WIDTH-1:0] d_ff, d_in;
   logic [SW-1:0]          sq_ff, sq_in;
   logic [VALUE_WIDTH-1:0] dv_ff, dv_in;
   logic [VALUE_WIDTH-1:0] q_ff, q_in;
   logic [VALUE_WIDTH-1:0] r_ff, r_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   is_prime_ff, is_prime_in;

   logic [VALUE_WIDTH-1:0] mag;
   logic [VALUE_WIDTH:0]   r_sh;
   logic [VALUE_WIDTH:0]   r_sub;
   logic [SW-1:0]          d_ext;

   always_comb begin
      mag = value;
      if (value[VALUE_WIDTH-1]) begin
         mag = VALUE_WIDTH'(0) - value;
      end
      d_ext = SW'(d_ff);
      r_sh  = {r_ff, q_ff[VALUE_WIDTH-1]};
      r_sub = r_sh - {1'b0, dv_ff};
   end

   always_comb begin
      n_in         = n_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      dv_in        = dv_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      is_prime_in  = is_prime_ff;
      if (cmd.load) begin
         n_in  = mag;
         d_in  = VALUE_WIDTH'(5);
         sq_in = SW'(25);
      end
      if (cmd.step) begin
         d_in  = d_ff + VALUE_WIDTH'(6);
         sq_in = sq_ff + (d_ext << 3) + (d_ext << 2) + SW'(36);
      end
      if (cmd.start_mod) begin
         case (cmd.div_sel)
            DIV_THREE: dv_in = VALUE_WIDTH'(3);
            DIV_D:     dv_in = d_ff;
            DIV_D2:    dv_in = d_ff + VALUE_WIDTH'(2);
            default:   dv_in = d_ff;
         endcase
         q_in   = n_ff;
         r_in   = '0;
         cnt_in = CW'(VALUE_WIDTH);
      end else if (cnt_ff != '0) begin
         q_in   = q_ff << 1;
         cnt_in = cnt_ff - CW'(1);
         if (r_sh >= {1'b0, dv_ff}) begin
            r_in = r_sub[VALUE_WIDTH-1:0];
         end else begin
            r_in = r_sh[VALUE_WIDTH-1:0];
         end
      end
      if (cmd.set_result) begin
         res_in = cmd.result_value;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
         is_prime_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      dv_ff       <= dv_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      res_ff      <= res_in;
      is_prime_ff <= is_prime_in;
   end

   always_comb begin
      status.below_two    = (n_ff < VALUE_WIDTH'(2));
      status.below_four   = (n_ff < VALUE_WIDTH'(4));
      status.even         = ~n_ff[0];
      status.square_above = (sq_ff > SW'(n_ff));
      status.mod_idle     = (cnt_ff == '0);
      status.rem_zero     = (r_ff == '0);
      status.out_busy     = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign is_prime  = is_prime_ff;

endmodule

`default_nettype wire

[rtl/tdpt_controller.sv]
// Controller of the prime test: sequences classification, the modulo checks
// and the divisor steps, then hands the result to the output. Uses tdpt_pkg.
`default_nettype none

module tdpt_controller
   import tdpt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_fire,
   output      logic       req_ready,
   input  wire status_type status,
   output      cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CLASSIFY = 3'd1;
   localparam logic [2:0] S_MOD3     = 3'd2;
   localparam logic [2:0] S_TEST     = 3'd3;
   localparam logic [2:0] S_MODD     = 3'd4;
   localparam logic [2:0] S_MODD2    = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.div_sel      = DIV_THREE;
      req_ready        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            if (status.below_two) begin
               cmd.set_result = 1'b1;
               state_in       = S_FINISH;
            end else if (status.below_four) begin
               cmd.set_result   = 1'b1;
               cmd.result_value = 1'b1;
               state_in         = S_FINISH;
            end else if (status.even) begin
               cmd.set_result = 1'b1;
               state_in       = S_FINISH;
            end else begin
               cmd.start_mod = 1'b1;
               cmd.div_sel   = DIV_THREE;
               state_in      = S_MOD3;
            end
         end
         S_MOD3: begin
            if (status.mod_idle) begin
               if (status.rem_zero) begin
                  cmd.set_result = 1'b1;
                  state_in       = S_FINISH;
               end else begin
                  state_in = S_TEST;
               end
            end
         end
         S_TEST: begin
            if (status.square_above) begin
               cmd.set_result   = 1'b1;
               cmd.result_value = 1'b1;
               state_in         = S_FINISH;
            end else begin
               cmd.start_mod = 1'b1;
               cmd.div_sel   = DIV_D;
               state_in      = S_MODD;
            end
         end
         S_MODD: begin
            if (status.mod_idle) begin
               if (status.rem_zero) begin
                  cmd.set_result = 1'b1;
                  state_in       = S_FINISH;
               end else begin
                  cmd.start_mod = 1'b1;
                  cmd.div_sel   = DIV_D2;
                  state_in      = S_MODD2;
               end
            end
         end
         S_MODD2: begin
            if (status.mod_idle) begin
               if (status.rem_zero) begin
                  cmd.set_result = 1'b1;
                  state_in       = S_FINISH;
               end else begin
                  cmd.step = 1'b1;
                  state_in = S_TEST;
               end
            end
         end
         S_FINISH: begin
            if (!status.out_busy) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/trial_division_prime_test.sv]
// Trial division prime test: one signed value in, one prime flag out per beat.
// Magnitudes below 4 and even magnitudes are decided in classification, odd multiples of three
// after the modulo-3 check, and other values after up to k divisor pairs d, d + 2
// tried (about sqrt(n) / 6), each check run by the bit-serial remainder unit,
// one quotient bit per cycle; one item at a time.
// The result beat becomes valid in the same cycle as req_tready rises again; reset drops rsp_tvalid.
`default_nettype none

module trial_division_prime_test
   import tdpt_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output      logic                                  req_tready,
   // Fields from bit 0: value.
   input  wire logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] req_tdata,
   output      logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // Fields from bit 0: is_prime.
   output      logic [7:0]                            rsp_tdata
);

   cmd_type    cmd;
   status_type status;
   logic       is_prime;
   logic       req_fire;

   assign req_fire = req_tvalid && req_tready;

   tdpt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   tdpt_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .value     (req_tdata[VALUE_WIDTH-1:0]),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .is_prime  (is_prime)
   );

   assign rsp_tdata = {7'd0, is_prime};

endmodule

`default_nettype wire

[tb/tb_trial_division_prime_test.sv]
// Self-checking testbench for trial_division_prime_test: it drives signed values
// into the request stream and compares each prime flag with its own trial-division
// predictor. It depends only on the RTL of the block.
`default_nettype none

module tb_trial_division_prime_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_WIDTH  = 32;
   localparam int DATA_W       = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_ITEMS = 77;

   localparam logic [1:0] READY_ALWAYS = 2'd0;
   localparam logic [1:0] READY_COIN   = 2'd1;
   localparam logic [1:0] READY_SPARSE = 2'd2;

   typedef struct {
      logic [DATA_W-1:0] value;
      bit                typed;
      bit                is_prime;
   } probe_row_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;

   bit   expected_prime_q [$];
   bit   expected_flag;
   int   error_count = 0;
   int   cycle_count = 0;
   int   burst_left  = 0;
   logic [1:0] ready_mode = READY_ALWAYS;
   int   mode_left   = 0;

   probe_row_type probe_table [23] = '{
      '{32'd0,          1'b1, 1'b0},
      '{32'd1,          1'b1, 1'b0},
      '{-32'sd1,        1'b1, 1'b0},
      '{32'd2,          1'b1, 1'b1},
      '{-32'sd2,        1'b1, 1'b1},
      '{32'd3,          1'b1, 1'b1},
      '{-32'sd3,        1'b1, 1'b1},
      '{32'd4,          1'b1, 1'b0},
      '{32'h8000_0000,  1'b1, 1'b0},
      '{32'h7FFF_FFFF,  1'b0, 1'b0},
      '{-32'sd7,        1'b0, 1'b0},
      '{32'd5,          1'b0, 1'b0},
      '{32'd9,          1'b0, 1'b0},
      '{32'd25,         1'b0, 1'b0},
      '{32'd35,         1'b0, 1'b0},
      '{32'd49,         1'b0, 1'b0},
      '{32'd121,        1'b0, 1'b0},
      '{-32'sd169,      1'b0, 1'b0},
      '{32'd65537,      1'b0, 1'b0},
      '{32'd2147483645, 1'b0, 1'b0},
      '{32'h5555_5555,  1'b0, 1'b0},
      '{32'hAAAA_AAAA,  1'b0, 1'b0},
      '{32'hFFFF_FFFB,  1'b0, 1'b0}
   };

   trial_division_prime_test #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit magnitude_is_prime(input logic [VALUE_WIDTH-1:0] raw);
      logic [VALUE_WIDTH-1:0] mag;
      longint unsigned        n;
      longint unsigned        d;
      mag = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
      n = mag;
      if (n < 2) return 1'b0;
      if (n < 4) return 1'b1;
      if (n % 2 == 0 || n % 3 == 0) return 1'b0;
      for (d = 5; d * d <= n; d += 6) begin
         if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic send_value(input logic [DATA_W-1:0] value, input bit prime_flag);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_prime_q = {expected_prime_q, prime_flag};
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 8);
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_for_results();
      while (expected_prime_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= 2'($urandom_range(0, 2));
         mode_left  <= $urandom_range(32, 400);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:      rsp_tready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_prime_q.size() == 0) begin
            $error("unexpected result beat: is_prime %0d", rsp_tdata[0]);
            error_count++;
         end else begin
            expected_flag = expected_prime_q.pop_front();
            if (rsp_tdata[0] !== expected_flag) begin
               $error("is_prime: expected %0d, actual %0d", expected_flag, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[7:1] !== 7'd0) begin
               $error("rsp_tdata padding: expected 0, actual %0h", rsp_tdata[7:1]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("trial_division_prime_test verification failed");
         $finish;
      end
   end

   initial begin
      int                     kind;
      logic [VALUE_WIDTH-1:0] mag;
      logic [VALUE_WIDTH-1:0] value;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (probe_table[i]) begin
         send_value(probe_table[i].value,
                    probe_table[i].typed ? probe_table[i].is_prime
                                         : magnitude_is_prime(probe_table[i].value));
      end

      // Let the pipeline run dry once before the random beats start.
      req_tvalid <= 1'b0;
      wait_for_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         kind = $urandom_range(0, 9);
         // Wide odd values are kept to multiples of three so that no slow prime
         // search runs on a full-width magnitude.
         case (kind)
            0:       mag = $urandom & ~32'd1;
            1:       mag = 32'd3 * $urandom_range(0, 715827882);
            2:       mag = $urandom_range(0, 1 << 20);
            default: mag = $urandom_range(0, 4095);
         endcase
         value = $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
         send_value(value, magnitude_is_prime(value));
      end

      req_tvalid <= 1'b0;
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("trial_division_prime_test verification clean");
      end else begin
         $display("trial_division_prime_test verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
